// ===== rtl/core/scbd_pkg.sv =====
// types and constants for the seismic channel block decoder
// used by every module of the block, no dependencies
`default_nettype none

package scbd_pkg;

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 12;
	localparam int INDEX_W = 10;
	localparam int WORD_W  = 32;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_COUNT_ERR = 2'd1;
	localparam logic [1:0] STATUS_CODE_ERR  = 2'd2;

	localparam logic [3:0] CODE_NIBBLE = 4'd0;
	localparam logic [3:0] CODE_DIFF8  = 4'd1;
	localparam logic [3:0] CODE_DIFF16 = 4'd2;
	localparam logic [3:0] CODE_DIFF24 = 4'd3;
	localparam logic [3:0] CODE_MAX    = 4'd4;

	localparam logic [COUNT_W-1:0] COUNT_MASK_HDR_LEN = 12'd8;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              block_start;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] sample;
		logic [INDEX_W-1:0]       sample_index;
		logic [WORD_W-1:0]        channel_number;
		logic [COUNT_W-1:0]       sample_count;
		logic [COUNT_W-1:0]       block_bytes;
		logic [1:0]               status;
		logic                     last;
	} out_item_t;

	// one queue entry: one or two results caused by a single byte
	typedef struct packed {
		logic [1:0]         status;
		logic               first;
		logic               two;
		logic               last0;
		logic               last1;
		logic [WORD_W-1:0]  diff0;
		logic [3:0]         diff1;
		logic [INDEX_W-1:0] idx0;
		logic [WORD_W-1:0]  channel;
		logic [COUNT_W-1:0] count;
		logic [COUNT_W-1:0] blen;
	} op_t;

endpackage

`default_nettype wire

// ===== rtl/core/scbd_front.sv =====
// front part: byte parsing, header checks and difference assembly
// depends on scbd_pkg, feeds scbd_queue
`default_nettype none

module scbd_front #(
	parameter int MAX_SAMPLES = 1000
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic              cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire scbd_pkg::in_item_t in_item,
	input  wire logic              q_full,
	output logic                   q_push,
	output scbd_pkg::op_t          q_data
);
	import scbd_pkg::*;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_PREFIX = 2'd1;
	localparam logic [1:0] PH_HEADER = 2'd2;
	localparam logic [1:0] PH_BODY   = 2'd3;

	logic               wide_q;
	logic [1:0]         phase_q, phase_d, phase_n;
	logic [1:0]         bp_q, bp_d, bp_n;
	logic [WORD_W-1:0]  hw_q, hw_d, hw_n;
	logic [15:0]        up_q, up_d, up_n;
	logic [WORD_W-1:0]  part_q, part_d, part_n;
	logic [COUNT_W-1:0] sd_q, sd_d, sd_n;
	logic [COUNT_W-1:0] blen_q, blen_n;
	logic [COUNT_W-1:0] cnt;
	logic [3:0]         code;
	logic [15:0]        prod;
	logic [COUNT_W:0]   sd_p1, sd_p2;
	logic [WORD_W-1:0]  part_sh;
	logic [BYTE_W-1:0]  b;
	logic               accept;
	logic               push_n;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign b        = in_item.data_byte;
	assign q_push   = accept && push_n;

	always_comb begin
		phase_d = phase_q;
		bp_d    = bp_q;
		hw_d    = hw_q;
		up_d    = up_q;
		part_d  = part_q;
		sd_d    = sd_q;
		if (in_item.block_start) begin
			phase_d = wide_q ? PH_PREFIX : PH_HEADER;
			bp_d    = 2'd0;
			hw_d    = '0;
			up_d    = '0;
			part_d  = '0;
			sd_d    = '0;
		end

		phase_n = phase_d;
		bp_n    = bp_d;
		hw_n    = hw_d;
		up_n    = up_d;
		part_n  = part_d;
		sd_n    = sd_d;
		blen_n  = blen_q;
		push_n  = 1'b0;
		prod    = '0;
		part_sh = {part_d[WORD_W-BYTE_W-1:0], b};
		cnt     = hw_d[COUNT_W-1:0];
		code    = hw_d[15:12];
		sd_p1   = {1'b0, sd_d} + 13'd1;
		sd_p2   = {1'b0, sd_d} + 13'd2;

		case (phase_d)
			PH_PREFIX: begin
				up_n = {up_d[7:0], b};
				if (bp_d == 2'd1) begin
					bp_n    = 2'd0;
					phase_n = PH_HEADER;
				end else begin
					bp_n = bp_d + 2'd1;
				end
			end
			PH_HEADER: begin
				hw_n = {hw_d[WORD_W-BYTE_W-1:0], b};
				cnt  = hw_n[COUNT_W-1:0];
				code = hw_n[15:12];
				prod = {4'd0, code} * {4'd0, cnt - 12'd1};
				if (bp_d == 2'd3) begin
					bp_n   = 2'd0;
					part_n = '0;
					if (cnt < 12'd2)
						blen_n = COUNT_MASK_HDR_LEN;
					else if (code == CODE_NIBBLE)
						blen_n = {1'b0, cnt[COUNT_W-1:1]} + COUNT_MASK_HDR_LEN;
					else
						blen_n = prod[COUNT_W-1:0] + COUNT_MASK_HDR_LEN;
					if (cnt != 12'd1 && cnt > COUNT_W'(MAX_SAMPLES)) begin
						push_n  = 1'b1;
						phase_n = PH_IDLE;
					end else if (cnt != 12'd1 && code > CODE_MAX) begin
						push_n  = 1'b1;
						phase_n = PH_IDLE;
					end else begin
						phase_n = PH_BODY;
					end
				end else begin
					bp_n = bp_d + 2'd1;
				end
			end
			PH_BODY: begin
				if (sd_d == '0) begin
					part_n = part_sh;
					if (bp_d == 2'd3) begin
						bp_n   = 2'd0;
						part_n = '0;
						push_n = 1'b1;
						sd_n   = sd_p1[COUNT_W-1:0];
						if (sd_p1 >= {1'b0, cnt})
							phase_n = PH_IDLE;
					end else begin
						bp_n = bp_d + 2'd1;
					end
				end else if (code == CODE_NIBBLE) begin
					push_n = 1'b1;
					if (sd_p1 >= {1'b0, cnt}) begin
						sd_n    = sd_p1[COUNT_W-1:0];
						phase_n = PH_IDLE;
					end else begin
						sd_n = sd_p2[COUNT_W-1:0];
						if (sd_p2 >= {1'b0, cnt})
							phase_n = PH_IDLE;
					end
				end else if (code <= CODE_MAX) begin
					part_n = part_sh;
					if ({2'd0, bp_d} + 4'd1 >= code) begin
						bp_n   = 2'd0;
						part_n = '0;
						push_n = 1'b1;
						sd_n   = sd_p1[COUNT_W-1:0];
						if (sd_p1 >= {1'b0, cnt})
							phase_n = PH_IDLE;
					end else begin
						bp_n = bp_d + 2'd1;
					end
				end else begin
					phase_n = PH_IDLE;
				end
			end
			default: begin
			end
		endcase
	end

	// queue entry
	always_comb begin
		q_data         = '0;
		q_data.channel = {up_n, hw_n[31:16]};
		q_data.count   = hw_n[COUNT_W-1:0];
		q_data.idx0    = sd_d[INDEX_W-1:0];
		q_data.blen    = blen_n;
		q_data.status  = STATUS_OK;
		q_data.last0   = sd_p1 >= {1'b0, cnt};
		q_data.last1   = sd_p2 >= {1'b0, cnt};
		if (phase_d == PH_HEADER) begin
			q_data.blen  = '0;
			q_data.last0 = 1'b1;
			if (cnt != 12'd1 && cnt > COUNT_W'(MAX_SAMPLES))
				q_data.status = STATUS_COUNT_ERR;
			else
				q_data.status = STATUS_CODE_ERR;
		end else if (sd_d == '0) begin
			q_data.first = 1'b1;
			q_data.diff0 = part_sh;
		end else if (code == CODE_NIBBLE) begin
			q_data.two   = !(sd_p1 >= {1'b0, cnt});
			q_data.diff0 = {{28{b[7]}}, b[7:4]};
			q_data.diff1 = b[3:0];
		end else begin
			case (code)
				CODE_DIFF8:  q_data.diff0 = {{24{part_sh[7]}}, part_sh[7:0]};
				CODE_DIFF16: q_data.diff0 = {{16{part_sh[15]}}, part_sh[15:0]};
				CODE_DIFF24: q_data.diff0 = {{8{part_sh[23]}}, part_sh[23:0]};
				default:     q_data.diff0 = part_sh;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q  <= 1'b0;
			phase_q <= PH_IDLE;
			bp_q    <= '0;
			hw_q    <= '0;
			up_q    <= '0;
			part_q  <= '0;
			sd_q    <= '0;
			blen_q  <= '0;
		end else begin
			if (cfg_wr_en)
				wide_q <= cfg_wr_data;
			if (accept) begin
				phase_q <= phase_n;
				bp_q    <= bp_n;
				hw_q    <= hw_n;
				up_q    <= up_n;
				part_q  <= part_n;
				sd_q    <= sd_n;
				blen_q  <= blen_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/scbd_queue.sv =====
// short queue of decoded entries between front and back
// depends on scbd_pkg
`default_nettype none

module scbd_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire scbd_pkg::op_t push_data,
	input  wire logic          pop,
	output scbd_pkg::op_t      head,
	output logic               empty,
	output logic               full
);
	import scbd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign empty   = cnt_q == '0;
	assign full    = cnt_q == CNT_W'(DEPTH);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/scbd_back.sv =====
// back part: running sum and result output register
// depends on scbd_pkg, drains scbd_queue
`default_nettype none

module scbd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire scbd_pkg::op_t head,
	input  wire logic          q_empty,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output scbd_pkg::out_item_t out_item
);
	import scbd_pkg::*;

	logic              valid_q;
	out_item_t         out_q, res;
	logic [WORD_W-1:0] acc_q, acc_n;
	logic              half_q, half_n;
	logic              load, emit;

	assign out_valid = valid_q;
	assign out_item  = out_q;
	assign load      = !valid_q || !out_stall;

	always_comb begin
		res                = '0;
		res.channel_number = head.channel;
		res.sample_count   = head.count;
		res.block_bytes    = head.blen;
		res.status         = head.status;
		acc_n              = acc_q;
		half_n             = half_q;
		emit               = 1'b0;
		q_pop              = 1'b0;
		if (load && half_q) begin
			// second nibble of the held entry
			emit             = 1'b1;
			acc_n            = acc_q + {{28{head.diff1[3]}}, head.diff1};
			res.sample       = acc_n;
			res.sample_index = head.idx0 + 10'd1;
			res.last         = head.last1;
			q_pop            = 1'b1;
			half_n           = 1'b0;
		end else if (load && !q_empty) begin
			emit             = 1'b1;
			res.sample_index = head.idx0;
			res.last         = head.last0;
			if (head.status == STATUS_OK) begin
				acc_n      = head.first ? head.diff0 : acc_q + head.diff0;
				res.sample = acc_n;
			end
			if (head.two)
				half_n = 1'b1;
			else
				q_pop = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
			acc_q   <= '0;
		end else begin
			if (load)
				valid_q <= emit;
			half_q <= half_n;
			acc_q  <= acc_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/seismic_channel_block_decoder.sv =====
// top level of the seismic channel block decoder
// depends on scbd_pkg, scbd_front, scbd_queue, scbd_back
// Takes one byte of a channel block per cycle unless in_stall is high and gives
// decoded samples in order. A byte that completes a sample is written into the
// queue and then registered into out_item; a 4-bit difference byte gives two
// samples, which the queue of QUEUE_DEPTH entries absorbs, so sustained input is
// one byte per cycle until the queue fills behind a stalled or nibble-bound output.
// Header errors give one result with status set and last high. The wide-channel
// mode set through cfg_wr_en is sampled at each block start.
`default_nettype none

module seismic_channel_block_decoder #(
	parameter int MAX_SAMPLES = 1000,
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic               cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire scbd_pkg::in_item_t in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output scbd_pkg::out_item_t     out_item
);
	import scbd_pkg::*;

	op_t  push_data, head;
	logic push, pop, empty, full;

	scbd_front #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.q_full     (full),
		.q_push     (push),
		.q_data     (push_data)
	);

	scbd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	scbd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (empty),
		.q_pop    (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

endmodule

`default_nettype wire

// ===== rtl/core/scbd_checker.sv =====
// port-level checks for the seismic channel block decoder
// depends on scbd_pkg, bound to seismic_channel_block_decoder
`default_nettype none

module scbd_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire scbd_pkg::out_item_t out_item
);
	import scbd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled output item changed");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != STATUS_OK |->
			out_item.last && out_item.sample == 0 && out_item.block_bytes == '0
			&& out_item.sample_index == '0)
		else $error("error item malformed");

	a_not_last_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == STATUS_OK && !out_item.last |->
			out_item.sample_count >= 12'd2)
		else $error("block continues past its count");

	a_short_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == STATUS_OK && out_item.sample_count < 12'd2 |->
			out_item.last && out_item.block_bytes == 12'd8)
		else $error("short block not closed");

endmodule

bind seismic_channel_block_decoder scbd_checker u_scbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_item (out_item)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for seismic_channel_block_decoder
// depends on scbd_pkg and the decoder rtl; predicts every sample in order and
// checks each result field by field; random idling on both channels is on except in one random-block run
`default_nettype none

module testbench;

	import scbd_pkg::*;

	localparam int SAMPLE_LIMIT = 1000;

	typedef enum logic [1:0] {PH_WAIT, PH_PREFIX, PH_HEADER, PH_BODY} dec_phase_e;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_wr_en = 1'b0;
	logic      cfg_wr_data = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;

	bit idling_on = 1'b1;
	int items_sent = 0;
	int mismatch_count = 0;

	// predictor state
	logic        wide_mode = 1'b0;
	dec_phase_e  dec_phase = PH_WAIT;
	int          byte_pos = 0;
	logic [31:0] hdr_word = '0;
	logic [15:0] upper_chan = '0;
	logic [31:0] partial_word = '0;
	logic [31:0] prev_sample = '0;
	int          samples_done = 0;

	out_item_t expected_samples[$];

	seismic_channel_block_decoder #(
		.MAX_SAMPLES(SAMPLE_LIMIT)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= idling_on && ($urandom_range(99) < 12);
	end

	function automatic logic [31:0] sext(input logic [31:0] v, input int bits);
		logic [31:0] m;
		if (bits >= 32)
			return v;
		m = 32'd1 << (bits - 1);
		v = v & ((32'd1 << bits) - 32'd1);
		return (v ^ m) - m;
	endfunction

	function automatic logic [COUNT_W-1:0] block_len();
		int c;
		int k;
		c = int'(hdr_word[11:0]);
		k = int'(hdr_word[15:12]);
		if (c < 2)
			return COUNT_W'(8);
		if (k == int'(CODE_NIBBLE))
			return COUNT_W'((c >> 1) + 8);
		return COUNT_W'(k * (c - 1) + 8);
	endfunction

	task automatic push_header_error(input logic [1:0] st);
		out_item_t e;
		e = '0;
		e.channel_number = {upper_chan, hdr_word[31:16]};
		e.sample_count = hdr_word[11:0];
		e.status = st;
		e.last = 1'b1;
		expected_samples.push_back(e);
	endtask

	task automatic add_sample(input logic [31:0] diff);
		out_item_t e;
		logic lst;
		prev_sample = prev_sample + diff;
		lst = (samples_done + 1 >= int'(hdr_word[11:0]));
		e.sample = prev_sample;
		e.sample_index = INDEX_W'(samples_done);
		e.channel_number = {upper_chan, hdr_word[31:16]};
		e.sample_count = hdr_word[11:0];
		e.block_bytes = block_len();
		e.status = STATUS_OK;
		e.last = lst;
		expected_samples.push_back(e);
		samples_done++;
		if (lst)
			dec_phase = PH_WAIT;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic s);
		logic [11:0] cnt;
		logic [3:0]  code;
		if (s) begin
			upper_chan = '0;
			hdr_word = '0;
			partial_word = '0;
			prev_sample = '0;
			samples_done = 0;
			byte_pos = 0;
			dec_phase = wide_mode ? PH_PREFIX : PH_HEADER;
		end
		code = hdr_word[15:12];
		case (dec_phase)
			PH_PREFIX: begin
				upper_chan = {upper_chan[7:0], b};
				byte_pos++;
				if (byte_pos >= 2) begin
					byte_pos = 0;
					dec_phase = PH_HEADER;
				end
			end
			PH_HEADER: begin
				hdr_word = {hdr_word[23:0], b};
				byte_pos++;
				if (byte_pos >= 4) begin
					byte_pos = 0;
					partial_word = '0;
					cnt = hdr_word[11:0];
					code = hdr_word[15:12];
					if (cnt != 12'd1 && int'(cnt) > SAMPLE_LIMIT) begin
						push_header_error(STATUS_COUNT_ERR);
						dec_phase = PH_WAIT;
					end else if (cnt != 12'd1 && code > CODE_MAX) begin
						push_header_error(STATUS_CODE_ERR);
						dec_phase = PH_WAIT;
					end else begin
						dec_phase = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				if (samples_done == 0) begin
					partial_word = {partial_word[23:0], b};
					byte_pos++;
					if (byte_pos >= 4) begin
						byte_pos = 0;
						prev_sample = '0;
						add_sample(partial_word);
						partial_word = '0;
					end
				end else if (code == CODE_NIBBLE) begin
					add_sample(sext({28'd0, b[7:4]}, 4));
					if (dec_phase == PH_BODY)
						add_sample(sext({28'd0, b[3:0]}, 4));
				end else if (code <= CODE_MAX) begin
					partial_word = {partial_word[23:0], b};
					byte_pos++;
					if (byte_pos >= int'(code)) begin
						byte_pos = 0;
						add_sample(sext(partial_word, 8 * int'(code)));
						partial_word = '0;
					end
				end else begin
					dec_phase = PH_WAIT;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_samples.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: sample %h idx %0d chan %h status %0d",
						out_item.sample, out_item.sample_index, out_item.channel_number,
						out_item.status);
			end else begin
				e = expected_samples.pop_front();
				if (out_item.sample !== e.sample || out_item.sample_index !== e.sample_index ||
					out_item.channel_number !== e.channel_number ||
					out_item.sample_count !== e.sample_count ||
					out_item.block_bytes !== e.block_bytes ||
					out_item.status !== e.status || out_item.last !== e.last) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch exp: sample %h idx %0d chan %h cnt %0d bytes %0d st %0d last %b",
							e.sample, e.sample_index, e.channel_number, e.sample_count,
							e.block_bytes, e.status, e.last);
						$display("         got: sample %h idx %0d chan %h cnt %0d bytes %0d st %0d last %b",
							out_item.sample, out_item.sample_index, out_item.channel_number,
							out_item.sample_count, out_item.block_bytes, out_item.status,
							out_item.last);
					end
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic s);
		while (idling_on && $urandom_range(99) < 12) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item <= '{data_byte: b, block_start: s};
		do
			@(posedge clk);
		while (in_stall);
		decode_byte(b, s);
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_wide(input logic v);
		wait_results_drained();
		repeat (16) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		wide_mode = v;
	endtask

	// keep < 0 cuts the block short at a random byte
	task automatic send_block(input logic [31:0] chan, input logic [3:0] code,
		input logic [11:0] cnt, input logic [31:0] first, input int keep);
		logic [7:0]  q[$];
		logic [31:0] hdr;
		int          n_diff;
		int          i;
		bit          bad;
		hdr = {chan[15:0], code, cnt};
		bad = (cnt != 12'd1) && (int'(cnt) > SAMPLE_LIMIT || code > CODE_MAX);
		n_diff = 0;
		if (!bad && cnt >= 12'd2)
			n_diff = (code == CODE_NIBBLE) ? int'(cnt) / 2 : int'(code) * (int'(cnt) - 1);
		if (wide_mode) begin
			q.push_back(chan[31:24]);
			q.push_back(chan[23:16]);
		end
		for (i = 3; i >= 0; i--)
			q.push_back(hdr[8*i +: 8]);
		if (!bad) begin
			for (i = 3; i >= 0; i--)
				q.push_back(first[8*i +: 8]);
			for (i = 0; i < n_diff; i++)
				q.push_back(8'($urandom));
		end
		if (keep < 0)
			keep = $urandom_range(1, q.size() - 1);
		else
			keep = q.size();
		for (i = 0; i < keep; i++)
			send_byte(q[i], i == 0);
		items_sent += keep;
	endtask

	task automatic send_random_block();
		int          r;
		int          n;
		int          cnt_i;
		logic [3:0]  code;
		logic [31:0] first;
		first = $urandom;
		if ($urandom_range(9) == 0)
			first = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
		r = $urandom_range(99);
		if (r < 6) begin
			n = $urandom_range(1, 3);
			repeat (n) send_byte(8'($urandom), 1'b0);
		end else if (r < 14) begin
			if ($urandom_range(1)) begin
				code = 4'($urandom);
				case ($urandom_range(2))
					0: cnt_i = SAMPLE_LIMIT + 1;
					1: cnt_i = 4095;
					default: cnt_i = $urandom_range(SAMPLE_LIMIT + 1, 4095);
				endcase
			end else begin
				code = 4'($urandom_range(int'(CODE_MAX) + 1, 15));
				cnt_i = $urandom_range(SAMPLE_LIMIT);
				if (cnt_i == 1)
					cnt_i = 0;
			end
			send_block($urandom, code, 12'(cnt_i), first, 0);
		end else begin
			code = 4'($urandom_range(int'(CODE_MAX)));
			r = $urandom_range(99);
			if (r < 10) begin
				cnt_i = 0;
			end else if (r < 20) begin
				cnt_i = 1;
				if ($urandom_range(1))
					code = 4'($urandom_range(int'(CODE_MAX) + 1, 15));
			end else if (r < 90) begin
				cnt_i = $urandom_range(2, 12);
			end else begin
				cnt_i = $urandom_range(13, 80);
			end
			send_block($urandom, code, 12'(cnt_i), first, ($urandom_range(9) == 0) ? -1 : 0);
		end
	endtask

	task automatic test_header_cases();
		send_block(32'h0000_ffff, CODE_NIBBLE, 12'd0, 32'h7fff_ffff, 0);
		send_block(32'hffff_0000, CODE_MAX, 12'hfff, 32'h0, 0);
		send_block(32'h0000_a5a5, 4'hf, 12'd2, 32'h0, 0);
		send_block(32'h0000_5a5a, 4'hf, 12'd1, 32'h8000_0000, 0);
	endtask

	task automatic test_random_blocks(input int target, input bit with_idling);
		int goal;
		goal = items_sent + target;
		idling_on = with_idling;
		while (items_sent < goal) begin
			send_random_block();
			if ($urandom_range(99) < 4)
				wait_results_drained();
		end
		idling_on = 1'b1;
	endtask

	task automatic test_long_block();
		send_block($urandom, CODE_NIBBLE, 12'(SAMPLE_LIMIT), $urandom, 0);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_wide(1'b0);
		test_header_cases();
		set_wide(1'b1);
		test_random_blocks(290, 1'b1);
		set_wide(1'b0);
		test_random_blocks(290, 1'b0);
		set_wide(1'b1);
		test_long_block();
		test_random_blocks(290, 1'b1);
		set_wide(1'b0);
		test_random_blocks(290, 1'b1);
		wait_results_drained();
		repeat (20) @(posedge clk);
		if (expected_samples.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
